// ===== sv/pipeline_decode_forward_unit_defines.svh =====
// Assertion macros shared by the decode/forward unit checkers.
// No dependencies; include by bare file name.
`ifndef PIPELINE_DECODE_FORWARD_UNIT_DEFINES_SVH
`define PIPELINE_DECODE_FORWARD_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PDFU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PDFU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pdfu_pkg.sv =====
// Types and constants for the pipeline decode/forward unit.
// No dependencies; compiled before the interfaces and modules.
package pdfu_pkg;

    typedef logic [3:0]  icode_t;
    typedef logic [3:0]  reg_id_t;
    typedef logic [63:0] word_t;

    localparam icode_t IC_RRMOVQ = 4'd2;
    localparam icode_t IC_IRMOVQ = 4'd3;
    localparam icode_t IC_RMMOVQ = 4'd4;
    localparam icode_t IC_MRMOVQ = 4'd5;
    localparam icode_t IC_OPQ    = 4'd6;
    localparam icode_t IC_JXX    = 4'd7;
    localparam icode_t IC_CALL   = 4'd8;
    localparam icode_t IC_RET    = 4'd9;
    localparam icode_t IC_PUSHQ  = 4'd10;
    localparam icode_t IC_POPQ   = 4'd11;

    localparam reg_id_t REG_SP   = 4'd4;
    localparam reg_id_t REG_NONE = 4'd15;

    // One decode slot as held in the input register.
    typedef struct packed {
        logic [11:0] instr_fields;
        word_t       val_p;
        word_t       rf_val_a;
        word_t       rf_val_b;
        logic [19:0] dest_tags;
        word_t       exec_val_e;
        word_t       mem_read_val;
        word_t       mem_alu_val;
        word_t       wb_load_val;
        word_t       wb_alu_val;
        logic [8:0]  hazard_info;
    } slot_t;

    // One decode result as held in the output register.
    typedef struct packed {
        reg_id_t src_a;
        reg_id_t src_b;
        reg_id_t dst_e;
        reg_id_t dst_m;
        word_t   val_a;
        word_t   val_b;
        logic    bubble_execute;
    } result_t;

endpackage

// ===== sv/pdfu_in_if.sv =====
// Input channel of the decode/forward unit: one instruction slot per word.
// Depends on pdfu_pkg.
interface pdfu_in_if;
    import pdfu_pkg::*;

    logic        valid;
    logic        ready;
    logic [11:0] instr_fields;
    word_t       val_p;
    word_t       rf_val_a;
    word_t       rf_val_b;
    logic [19:0] dest_tags;
    word_t       exec_val_e;
    word_t       mem_read_val;
    word_t       mem_alu_val;
    word_t       wb_load_val;
    word_t       wb_alu_val;
    logic [8:0]  hazard_info;

    modport source (
        output valid, instr_fields, val_p, rf_val_a, rf_val_b, dest_tags,
               exec_val_e, mem_read_val, mem_alu_val, wb_load_val, wb_alu_val,
               hazard_info,
        input  ready
    );

    modport sink (
        input  valid, instr_fields, val_p, rf_val_a, rf_val_b, dest_tags,
               exec_val_e, mem_read_val, mem_alu_val, wb_load_val, wb_alu_val,
               hazard_info,
        output ready
    );
endinterface

// ===== sv/pdfu_out_if.sv =====
// Output channel of the decode/forward unit: one decode result per word.
// Depends on pdfu_pkg.
interface pdfu_out_if;
    import pdfu_pkg::*;

    logic    valid;
    logic    ready;
    reg_id_t src_a;
    reg_id_t src_b;
    reg_id_t dst_e;
    reg_id_t dst_m;
    word_t   val_a;
    word_t   val_b;
    logic    bubble_execute;

    modport source (
        output valid, src_a, src_b, dst_e, dst_m, val_a, val_b, bubble_execute,
        input  ready
    );

    modport sink (
        input  valid, src_a, src_b, dst_e, dst_m, val_a, val_b, bubble_execute,
        output ready
    );
endinterface

// ===== sv/pipeline_decode_forward_unit.sv =====
// Y86-64 decode stage: register ids, operand forwarding and execute bubble.
// Depends on pdfu_pkg, pdfu_in_if and pdfu_out_if.
//
// Usage:
//   req carries one instruction slot per word: the decode fields, the next
//   PC, register file read data, the five downstream destination tags with
//   their values, and the execute-stage hazard info.
//   rsp carries one result word per slot: src/dst ids, operands A and B and
//   the bubble request for the execute register.
//   An accepted slot is registered first in the input register, then in the
//   result register, which drives rsp. Decode, the five-way forwarding
//   compare and the hazard check sit between the two registers.
//   Throughput is one word per cycle while rsp.ready stays high.
//   Reset empties both registers; req.ready is high from reset on.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; req.ready drops only when both are full, and
//   rises again in the same cycle rsp.ready returns.
module pipeline_decode_forward_unit (
    input  logic           clk,
    input  logic           rst_n,
    pdfu_in_if.sink        req,
    pdfu_out_if.source     rsp
);
    import pdfu_pkg::*;

    logic    s1_valid_reg;
    slot_t   s1_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    out_free;
    logic    s1_advance;
    logic    req_take;
    result_t out_next;

    icode_t  icode;
    reg_id_t ra;
    reg_id_t rb;
    icode_t  e_icode;
    reg_id_t e_dstm;
    logic    cnd;

    // Priority: execute, memory load, memory ALU, writeback load, writeback ALU.
    function automatic word_t pick_operand(input reg_id_t src, input slot_t s,
                                           input word_t rf);
        word_t v;
        if (src == REG_NONE)
            v = '0;
        else if (src == s.dest_tags[19:16])
            v = s.exec_val_e;
        else if (src == s.dest_tags[15:12])
            v = s.mem_read_val;
        else if (src == s.dest_tags[11:8])
            v = s.mem_alu_val;
        else if (src == s.dest_tags[7:4])
            v = s.wb_load_val;
        else if (src == s.dest_tags[3:0])
            v = s.wb_alu_val;
        else
            v = rf;
        return v;
    endfunction

    assign out_free   = !out_valid_reg || rsp.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign req.ready  = !s1_valid_reg || out_free;
    assign req_take   = req.valid && req.ready;

    assign icode   = s1_reg.instr_fields[11:8];
    assign ra      = s1_reg.instr_fields[7:4];
    assign rb      = s1_reg.instr_fields[3:0];
    assign e_icode = s1_reg.hazard_info[8:5];
    assign e_dstm  = s1_reg.hazard_info[4:1];
    assign cnd     = s1_reg.hazard_info[0];

    always_comb
    begin
        out_next = '0;
        out_next.src_a = REG_NONE;
        out_next.src_b = REG_NONE;
        out_next.dst_e = REG_NONE;
        out_next.dst_m = REG_NONE;

        case (icode)
            IC_RRMOVQ, IC_RMMOVQ, IC_OPQ, IC_PUSHQ: out_next.src_a = ra;
            IC_POPQ, IC_RET:                        out_next.src_a = REG_SP;
            default:                                out_next.src_a = REG_NONE;
        endcase

        case (icode)
            IC_OPQ, IC_RMMOVQ, IC_MRMOVQ:           out_next.src_b = rb;
            IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET:     out_next.src_b = REG_SP;
            default:                                out_next.src_b = REG_NONE;
        endcase

        case (icode)
            IC_RRMOVQ, IC_IRMOVQ, IC_OPQ:           out_next.dst_e = rb;
            IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET:     out_next.dst_e = REG_SP;
            default:                                out_next.dst_e = REG_NONE;
        endcase

        case (icode)
            IC_MRMOVQ, IC_POPQ:                     out_next.dst_m = ra;
            default:                                out_next.dst_m = REG_NONE;
        endcase

        // Call and jump carry the next PC in place of operand A.
        if (icode == IC_CALL || icode == IC_JXX)
            out_next.val_a = s1_reg.val_p;
        else
            out_next.val_a = pick_operand(out_next.src_a, s1_reg, s1_reg.rf_val_a);
        out_next.val_b = pick_operand(out_next.src_b, s1_reg, s1_reg.rf_val_b);

        // Mispredicted jump, or load-use on either source.
        out_next.bubble_execute =
            (e_icode == IC_JXX && !cnd) ||
            ((e_icode == IC_MRMOVQ || e_icode == IC_POPQ) &&
             (e_dstm == out_next.src_a || e_dstm == out_next.src_b));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_reg.instr_fields <= req.instr_fields;
            s1_reg.val_p        <= req.val_p;
            s1_reg.rf_val_a     <= req.rf_val_a;
            s1_reg.rf_val_b     <= req.rf_val_b;
            s1_reg.dest_tags    <= req.dest_tags;
            s1_reg.exec_val_e   <= req.exec_val_e;
            s1_reg.mem_read_val <= req.mem_read_val;
            s1_reg.mem_alu_val  <= req.mem_alu_val;
            s1_reg.wb_load_val  <= req.wb_load_val;
            s1_reg.wb_alu_val   <= req.wb_alu_val;
            s1_reg.hazard_info  <= req.hazard_info;
        end
        if (s1_advance)
            out_reg <= out_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.src_a          = out_reg.src_a;
    assign rsp.src_b          = out_reg.src_b;
    assign rsp.dst_e          = out_reg.dst_e;
    assign rsp.dst_m          = out_reg.dst_m;
    assign rsp.val_a          = out_reg.val_a;
    assign rsp.val_b          = out_reg.val_b;
    assign rsp.bubble_execute = out_reg.bubble_execute;

endmodule

// ===== sv/pdfu_checker.sv =====
// Port-level checks for the decode/forward unit, bound to the top level.
// Depends on pdfu_pkg and pipeline_decode_forward_unit_defines.svh.
`include "pipeline_decode_forward_unit_defines.svh"

module pdfu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input pdfu_pkg::reg_id_t rsp_src_b,
    input pdfu_pkg::word_t   rsp_val_a,
    input pdfu_pkg::word_t   rsp_val_b
);
    import pdfu_pkg::*;

    // Hold a stalled result word.
    `PDFU_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_val_a) && $stable(rsp_val_b), "stalled result word changed")

    // Advance an accepted word through the input register to the output when not stalled.
    `PDFU_ASSERT(a_latency, clk, rst_n, (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid, "accepted word did not reach the output")

    // Drive operand B to zero when there is no source B.
    `PDFU_ASSERT(a_no_src_b, clk, rst_n, rsp_valid && rsp_src_b == REG_NONE |-> rsp_val_b == '0, "operand B nonzero with no source")

    // Keep the input open whenever the output register is empty.
    `PDFU_ASSERT_ALWAYS(a_ready_when_empty, clk, !rsp_valid |-> req_ready, "input blocked with empty output")

endmodule

bind pipeline_decode_forward_unit pdfu_checker u_pdfu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_src_b (rsp.src_b),
    .rsp_val_a (rsp.val_a),
    .rsp_val_b (rsp.val_b)
);

// ===== test/pipeline_decode_forward_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench for pipeline_decode_forward_unit: drives instruction slots through
// valid/ready with random gaps and checks every result word against a predictor.
// Depends on pdfu_pkg, pdfu_in_if, pdfu_out_if and the decode/forward unit.
module pipeline_decode_forward_unit_test;
    import pdfu_pkg::*;

    typedef enum logic [1:0] {
        PH_RX_SLOW,
        PH_TX_SLOW,
        PH_FULL_RATE
    } idle_phase_t;

    typedef struct {
        slot_t       slot;
        idle_phase_t phase;
        bit          drain_first;
        bit          rx_hold;
    } pending_slot_t;

    localparam int RANDOM_SLOTS   = 1150;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES  = 8;

    logic clk = 1'b0;
    logic rst_n;

    pdfu_in_if  in_ch ();
    pdfu_out_if out_ch ();

    pipeline_decode_forward_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_ch),
        .rsp   (out_ch)
    );

    pending_slot_t pending_slots[$];
    result_t       expected_results[$];
    slot_t         cur_slot;
    idle_phase_t   rx_phase = PH_RX_SLOW;
    logic          hold_kick = 1'b0;
    int unsigned   rx_hold_left = 0;
    int unsigned   n_accepted = 0;
    int unsigned   n_checked = 0;
    int unsigned   errors = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Operand select: first matching downstream tag wins, else register file.
    function automatic word_t forward_operand(reg_id_t src, slot_t s, word_t rf);
        reg_id_t tag_e, tag_mm, tag_me, tag_wm, tag_we;
        {tag_e, tag_mm, tag_me, tag_wm, tag_we} = s.dest_tags;
        if (src == REG_NONE) return '0;
        if (src == tag_e)    return s.exec_val_e;
        if (src == tag_mm)   return s.mem_read_val;
        if (src == tag_me)   return s.mem_alu_val;
        if (src == tag_wm)   return s.wb_load_val;
        if (src == tag_we)   return s.wb_alu_val;
        return rf;
    endfunction

    function automatic result_t decode_slot(slot_t s);
        icode_t  icode;
        reg_id_t ra, rb;
        icode_t  ex_icode;
        reg_id_t ex_dstm;
        logic    cnd;
        result_t r;
        {icode, ra, rb} = s.instr_fields;
        {ex_icode, ex_dstm, cnd} = s.hazard_info;
        case (icode)
            IC_RRMOVQ, IC_RMMOVQ, IC_OPQ, IC_PUSHQ: r.src_a = ra;
            IC_POPQ, IC_RET:                        r.src_a = REG_SP;
            default:                                r.src_a = REG_NONE;
        endcase
        case (icode)
            IC_OPQ, IC_RMMOVQ, IC_MRMOVQ:           r.src_b = rb;
            IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET:     r.src_b = REG_SP;
            default:                                r.src_b = REG_NONE;
        endcase
        case (icode)
            IC_RRMOVQ, IC_IRMOVQ, IC_OPQ:           r.dst_e = rb;
            IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET:     r.dst_e = REG_SP;
            default:                                r.dst_e = REG_NONE;
        endcase
        r.dst_m = (icode == IC_MRMOVQ || icode == IC_POPQ) ? ra : REG_NONE;
        if (icode == IC_CALL || icode == IC_JXX)
            r.val_a = s.val_p;
        else
            r.val_a = forward_operand(r.src_a, s, s.rf_val_a);
        r.val_b = forward_operand(r.src_b, s, s.rf_val_b);
        // Plain id equality: a none tag in execute matches a none source.
        r.bubble_execute = (ex_icode == IC_JXX && !cnd) ||
                           ((ex_icode == IC_MRMOVQ || ex_icode == IC_POPQ) &&
                            (ex_dstm == r.src_a || ex_dstm == r.src_b));
        return r;
    endfunction

    function automatic word_t random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Bias register ids toward a few values so tags collide often.
    function automatic reg_id_t pick_reg();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) return reg_id_t'($urandom_range(0, 3));
        if (r == 4) return REG_SP;
        if (r == 5) return REG_NONE;
        return reg_id_t'($urandom_range(0, 15));
    endfunction

    function automatic reg_id_t pick_tag(reg_id_t ra, reg_id_t rb);
        case ($urandom_range(0, 7))
            0:       return ra;
            1:       return rb;
            2:       return REG_SP;
            3:       return REG_NONE;
            default: return reg_id_t'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic slot_t random_slot();
        slot_t   s;
        icode_t  icode;
        icode_t  ex_icode;
        reg_id_t ra, rb;
        if ($urandom_range(0, 99) < 88)
            icode = icode_t'($urandom_range(0, 11));
        else
            icode = icode_t'($urandom_range(12, 15));
        ra = pick_reg();
        rb = pick_reg();
        case ($urandom_range(0, 9))
            0, 1, 2: ex_icode = IC_JXX;
            3, 4:    ex_icode = IC_MRMOVQ;
            5, 6:    ex_icode = IC_POPQ;
            default: ex_icode = icode_t'($urandom_range(0, 15));
        endcase
        s.instr_fields = {icode, ra, rb};
        s.val_p        = random_word();
        s.rf_val_a     = random_word();
        s.rf_val_b     = random_word();
        s.dest_tags    = {pick_tag(ra, rb), pick_tag(ra, rb), pick_tag(ra, rb),
                          pick_tag(ra, rb), pick_tag(ra, rb)};
        s.exec_val_e   = random_word();
        s.mem_read_val = random_word();
        s.mem_alu_val  = random_word();
        s.wb_load_val  = random_word();
        s.wb_alu_val   = random_word();
        s.hazard_info  = {ex_icode, pick_tag(ra, rb), 1'($urandom_range(0, 1))};
        return s;
    endfunction

    task automatic add_slot(slot_t s, idle_phase_t ph, bit drain, bit hold);
        pending_slot_t p;
        p.slot        = s;
        p.phase       = ph;
        p.drain_first = drain;
        p.rx_hold     = hold;
        pending_slots.push_back(p);
    endtask

    task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // Driver: hold the word until taken, then offer the next or idle.
    always @(posedge clk or negedge rst_n)
    begin : drive_slots
        pending_slot_t nxt;
        logic          next_valid;
        logic          stay_idle;
        logic          kick;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            hold_kick   <= 1'b0;
        end
        else
        begin
            kick       = 1'b0;
            next_valid = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(decode_slot(cur_slot));
                n_accepted <= n_accepted + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_slots.size() != 0)
            begin
                nxt = pending_slots[0];
                case (nxt.phase)
                    PH_RX_SLOW: stay_idle = ($urandom_range(0, 99) < 29);
                    PH_TX_SLOW: stay_idle = ($urandom_range(0, 99) < 74);
                    default:    stay_idle = 1'b0;
                endcase
                // Pause until every word in flight has come back.
                if (nxt.drain_first && (in_ch.valid || n_accepted != n_checked))
                    stay_idle = 1'b1;
                if (!stay_idle)
                begin
                    void'(pending_slots.pop_front());
                    in_ch.instr_fields <= nxt.slot.instr_fields;
                    in_ch.val_p        <= nxt.slot.val_p;
                    in_ch.rf_val_a     <= nxt.slot.rf_val_a;
                    in_ch.rf_val_b     <= nxt.slot.rf_val_b;
                    in_ch.dest_tags    <= nxt.slot.dest_tags;
                    in_ch.exec_val_e   <= nxt.slot.exec_val_e;
                    in_ch.mem_read_val <= nxt.slot.mem_read_val;
                    in_ch.mem_alu_val  <= nxt.slot.mem_alu_val;
                    in_ch.wb_load_val  <= nxt.slot.wb_load_val;
                    in_ch.wb_alu_val   <= nxt.slot.wb_alu_val;
                    in_ch.hazard_info  <= nxt.slot.hazard_info;
                    cur_slot           <= nxt.slot;
                    rx_phase           <= nxt.phase;
                    kick               = nxt.rx_hold;
                    next_valid         = 1'b1;
                end
            end
            in_ch.valid <= next_valid;
            hold_kick   <= kick;
        end
    end

    // Long receiver stall so the block fills and drops req.ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rx_hold_left <= 0;
        else if (hold_kick)
            rx_hold_left <= RX_HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Monitor: compare each taken result word with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_t want;
        logic    rdy;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word: expected none actual %h %h",
                             $time, out_ch.val_a, out_ch.val_b);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("src_a", 64'(want.src_a), 64'(out_ch.src_a));
                    check_field("src_b", 64'(want.src_b), 64'(out_ch.src_b));
                    check_field("dst_e", 64'(want.dst_e), 64'(out_ch.dst_e));
                    check_field("dst_m", 64'(want.dst_m), 64'(out_ch.dst_m));
                    check_field("val_a", want.val_a, out_ch.val_a);
                    check_field("val_b", want.val_b, out_ch.val_b);
                    check_field("bubble_execute", 64'(want.bubble_execute),
                                64'(out_ch.bubble_execute));
                    n_checked <= n_checked + 1;
                end
            end
            case (rx_phase)
                PH_RX_SLOW: rdy = ($urandom_range(0, 99) >= 74);
                PH_TX_SLOW: rdy = ($urandom_range(0, 99) >= 29);
                default:    rdy = 1'b1;
            endcase
            if (rx_hold_left != 0)
                rdy = 1'b0;
            out_ch.ready <= rdy;
        end
    end

    initial
    begin
        slot_t       s;
        idle_phase_t ph;
        int          k;
        int          i;

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.instr_fields, in_ch.val_p, in_ch.rf_val_a, in_ch.rf_val_b,
         in_ch.dest_tags, in_ch.exec_val_e, in_ch.mem_read_val, in_ch.mem_alu_val,
         in_ch.wb_load_val, in_ch.wb_alu_val, in_ch.hazard_info} = '0;
        out_ch.ready = 1'b0;
        cur_slot = '0;

        // Every icode, the defined ones and the undefined ones.
        for (k = 0; k < 16; k++)
        begin
            s = random_slot();
            s.instr_fields[11:8] = k[3:0];
            add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);
        end
        s = '0;
        add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);
        s = '1;
        add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);

        // Walk the forwarding priority down to the register file.
        for (k = 0; k <= 5; k++)
        begin
            s = random_slot();
            s.instr_fields = {IC_OPQ, 4'd3, 4'd3};
            for (i = 0; i < 5; i++)
                s.dest_tags[19 - 4 * i -: 4] = (i >= k) ? 4'd3 : 4'd9;
            s.hazard_info = {IC_IRMOVQ, REG_SP, 1'b1};
            add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);
        end

        // No source: tags all none must not forward.
        s = random_slot();
        s.instr_fields = {IC_IRMOVQ, REG_NONE, 4'd2};
        s.dest_tags = '1;
        s.hazard_info = {IC_IRMOVQ, REG_SP, 1'b1};
        add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);

        // Mispredicted jump, taken jump, load-use on A and B, none tag match.
        s = random_slot();
        s.hazard_info = {IC_JXX, 4'd0, 1'b0};
        add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);
        s.hazard_info = {IC_JXX, 4'd0, 1'b1};
        s.instr_fields = {IC_RRMOVQ, 4'd1, 4'd2};
        add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);
        s = random_slot();
        s.instr_fields = {IC_RRMOVQ, 4'd2, 4'd7};
        s.hazard_info = {IC_MRMOVQ, 4'd2, 1'b1};
        add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);
        s = random_slot();
        s.instr_fields = {IC_OPQ, 4'd1, 4'd5};
        s.hazard_info = {IC_POPQ, 4'd5, 1'b1};
        add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);
        s = random_slot();
        s.instr_fields = {IC_IRMOVQ, REG_NONE, 4'd6};
        s.hazard_info = {IC_MRMOVQ, REG_NONE, 1'b1};
        add_slot(s, PH_RX_SLOW, 1'b0, 1'b0);

        for (k = 0; k < RANDOM_SLOTS; k++)
        begin
            if (k < RANDOM_SLOTS / 3)
                ph = PH_RX_SLOW;
            else if (k < 2 * RANDOM_SLOTS / 3)
                ph = PH_TX_SLOW;
            else
                ph = PH_FULL_RATE;
            add_slot(random_slot(), ph,
                     k == RANDOM_SLOTS / 3 || k == 2 * RANDOM_SLOTS / 3,
                     k == 2 * RANDOM_SLOTS / 3 + 40 || k == RANDOM_SLOTS - 60);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_slots.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (n_accepted != n_checked)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
